// File: design/svis_pkg.sv
// Shared types, constants and decode functions for the stack VM instruction splitter.
package svis_pkg;

    localparam logic [7:0] LIT_MASK  = 8'h9f;
    localparam logic [7:0] LIT_CODE  = 8'h80;
    localparam logic [15:0] LOAD_BASE_RESET = 16'h0100;

    localparam logic [1:0] CLASS_BREAK    = 2'd0;
    localparam logic [1:0] CLASS_RESERVED = 2'd1;
    localparam logic [1:0] CLASS_LITERAL  = 2'd2;
    localparam logic [1:0] CLASS_ORDINARY = 2'd3;

    localparam logic [1:0] REG_LOAD_BASE = 2'd0;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [15:0] address;
        logic [1:0]  byte_count;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
        logic        truncated;
    } instr_rec_t;

    typedef struct packed {
        logic [1:0] instr_class;
        logic [4:0] op_index;
        logic       show_short;
        logic       show_keep;
        logic       show_return;
    } instr_info_t;

    function automatic logic is_literal(input logic [7:0] op);
        is_literal = ((op & LIT_MASK) == LIT_CODE);
    endfunction

    function automatic instr_info_t classify(input logic [7:0] op, input logic trunc);
        instr_info_t info;
        info = '0;
        if (!trunc) begin
            if (op[4:0] != 5'd0) begin
                info.instr_class = CLASS_ORDINARY;
                info.op_index    = op[4:0];
                info.show_short  = op[5];
                info.show_keep   = op[7];
                info.show_return = op[6];
            end else if (op[7]) begin
                info.instr_class = CLASS_LITERAL;
                info.op_index    = {2'b00, op[7:5]};
                info.show_short  = op[5];
                info.show_return = op[6];
            end else begin
                info.op_index    = {2'b00, op[7:5]};
                info.instr_class = (op[7:5] == 3'd0) ? CLASS_BREAK : CLASS_RESERVED;
            end
        end
        classify = info;
    endfunction

endpackage

// File: design/svis_front.sv
// Front end: accepts image bytes and groups them into instruction records.
module svis_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         load_base,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    input  logic                push_ready,
    output svis_pkg::instr_rec_t push_rec
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] start_reg, start_next;
    logic [1:0]  need_reg, need_next;
    logic [1:0]  held_reg, held_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  imm_reg, imm_next;
    logic        accept;
    logic        emit;
    logic        start_new;

    assign in_ready  = push_ready;
    assign accept    = in_valid && push_ready;
    assign start_new = (held_reg == 2'd0) || (need_reg == 2'd0);
    assign push      = accept && emit;

    always_comb begin
        pos_next    = pos_reg;
        start_next  = start_reg;
        need_next   = need_reg;
        held_next   = held_reg;
        opcode_next = opcode_reg;
        imm_next    = imm_reg;
        emit        = 1'b0;
        push_rec    = '0;
        push_rec.address = load_base + (start_new ? pos_reg : start_reg);
        if (start_new) begin
            push_rec.byte_count = 2'd1;
            push_rec.first_byte = in_byte;
            if (!svis_pkg::is_literal(in_byte)) begin
                emit = 1'b1;
            end else if (in_last) begin
                emit = 1'b1;
                push_rec.truncated = 1'b1;
            end
        end else if (need_reg == 2'd1) begin
            emit = 1'b1;
            push_rec.first_byte = opcode_reg;
            if (held_reg >= 2'd2) begin
                push_rec.byte_count  = 2'd3;
                push_rec.second_byte = imm_reg;
                push_rec.third_byte  = in_byte;
            end else begin
                push_rec.byte_count  = 2'd2;
                push_rec.second_byte = in_byte;
            end
        end else begin
            push_rec.first_byte  = opcode_reg;
            push_rec.second_byte = in_byte;
            push_rec.byte_count  = 2'd2;
            if (in_last) begin
                emit = 1'b1;
                push_rec.truncated = 1'b1;
            end
        end

        if (accept) begin
            if (start_new) begin
                start_next  = pos_reg;
                opcode_next = in_byte;
                if (emit) begin
                    held_next = 2'd0;
                    need_next = 2'd0;
                end else begin
                    held_next = 2'd1;
                    need_next = in_byte[5] ? 2'd2 : 2'd1;
                end
            end else if (emit) begin
                held_next = 2'd0;
                need_next = 2'd0;
            end else begin
                imm_next  = in_byte;
                held_next = 2'd2;
                need_next = 2'd1;
            end
            if (in_last) begin
                pos_next  = '0;
                held_next = 2'd0;
                need_next = 2'd0;
            end else begin
                pos_next = pos_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            start_reg  <= '0;
            need_reg   <= '0;
            held_reg   <= '0;
            opcode_reg <= '0;
            imm_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            need_reg   <= need_next;
            held_reg   <= held_next;
            opcode_reg <= opcode_next;
            imm_reg    <= imm_next;
        end
    end

endmodule

// File: design/svis_fifo.sv
// Two-entry queue of instruction records between the front and back ends.
module svis_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    output logic                 push_ready,
    input  svis_pkg::instr_rec_t push_rec,
    output logic                 pop_valid,
    input  logic                 pop,
    output svis_pkg::instr_rec_t pop_rec
);

    svis_pkg::instr_rec_t mem_reg [svis_pkg::FIFO_DEPTH];
    logic [$clog2(svis_pkg::FIFO_DEPTH+1)-1:0] count_reg, count_next;
    logic [$clog2(svis_pkg::FIFO_DEPTH)-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic do_push, do_pop;

    assign push_ready = (count_reg != svis_pkg::FIFO_DEPTH[$bits(count_reg)-1:0]);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_rec    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: design/svis_back.sv
// Back end: classifies queued records and holds the result in the output register.
module svis_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    output logic                 rec_pop,
    input  svis_pkg::instr_rec_t rec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [55:0]          out_data,
    output logic                 out_trunc
);

    logic                  valid_reg;
    svis_pkg::instr_rec_t  rec_reg;
    svis_pkg::instr_info_t info_reg;

    assign rec_pop   = rec_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_trunc = rec_reg.truncated;
    assign out_data  = {4'b0000,
                        info_reg.show_return, info_reg.show_keep, info_reg.show_short,
                        info_reg.op_index, info_reg.instr_class,
                        rec_reg.third_byte, rec_reg.second_byte, rec_reg.first_byte,
                        rec_reg.byte_count, rec_reg.address};

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            rec_reg  <= rec;
            info_reg <= svis_pkg::classify(rec.first_byte, rec.truncated);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// File: design/stack_vm_instruction_splitter_unit.sv
// Top level of the stack VM instruction splitter: front end, queue, back end and register port.
//
//  Channel  Direction  Transfer                 Payload
//  s_*      in         one image byte           tdata = byte_value, tlast = last_byte
//  m_*      out        one instruction result   tdata = result fields, tuser = truncated
//  APB      in/out     register access          load_base at address 0
//
// One byte is taken per cycle while s_tready is high; a result passes through the queue and the output register.
// The front end updates its registered grouping state with every byte that it accepts.
// Reset is synchronous and active low; it clears position and grouping state and
// sets load_base to 0x0100. A stalled result side fills the two-entry queue and the
// output register before s_tready drops.
module stack_vm_instruction_splitter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // address, byte_count, first_byte, second_byte, third_byte,
                                   // instr_class, op_index, show_short, show_keep, show_return
    output logic        m_tuser,   // [0] truncated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]          load_base_reg;
    logic                 push, push_ready, rec_valid, rec_pop;
    svis_pkg::instr_rec_t push_rec, rec;

    assign pready = 1'b1;
    assign prdata = (paddr == svis_pkg::REG_LOAD_BASE) ? {16'h0000, load_base_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg <= svis_pkg::LOAD_BASE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == svis_pkg::REG_LOAD_BASE) begin
            load_base_reg <= pwdata[15:0];
        end
    end

    svis_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_base  (load_base_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    svis_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (rec_valid),
        .pop        (rec_pop),
        .pop_rec    (rec)
    );

    svis_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_pop   (rec_pop),
        .rec       (rec),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_trunc (m_tuser)
    );

endmodule

// File: tb/tb_stack_vm_instruction_splitter_unit.sv
// Self-checking testbench for the stack VM instruction splitter.
`timescale 1ns / 100ps

module tb_stack_vm_instruction_splitter_unit;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_IMAGE_BYTES = 200;
    localparam logic [1:0] LOAD_BASE_ADDR = 2'(4 * svis_pkg::REG_LOAD_BASE);

    typedef struct packed {
        logic [15:0] address;
        logic [1:0]  byte_count;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
        logic [1:0]  instr_class;
        logic [4:0]  op_index;
        logic        show_short;
        logic        show_keep;
        logic        show_return;
        logic        truncated;
    } split_result_t;

    typedef struct {
        logic [7:0]    value;
        logic          last;
        bit            typed;
        split_result_t result;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] byte_value
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [15:0] address, [17:16] byte_count, [25:18] first_byte,
                                    // [33:26] second_byte, [41:34] third_byte,
                                    // [43:42] instr_class, [48:44] op_index, [49] show_short,
                                    // [50] show_keep, [51] show_return
    logic        m_tuser;           // [0] truncated
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    split_result_t pending_results[$];
    directed_row_t directed_rows[$];
    int            error_count = 0;
    int            stall_cycles = 0;
    bit            steady_flow = 1'b0;

    logic [15:0] img_base;
    logic [15:0] img_pos;
    logic [15:0] img_start;
    logic [1:0]  img_need;
    logic [1:0]  img_held;
    logic [7:0]  img_opcode;
    logic [7:0]  img_high;

    stack_vm_instruction_splitter_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic split_result_t make_result(
        input logic [15:0] address, input logic [1:0] byte_count, input logic [7:0] b1,
        input logic [7:0] b2, input logic [7:0] b3, input logic [1:0] instr_class,
        input logic [4:0] op_index, input logic sh, input logic kp, input logic rt,
        input logic trunc);
        split_result_t r;
        r.address     = address;
        r.byte_count  = byte_count;
        r.first_byte  = b1;
        r.second_byte = b2;
        r.third_byte  = b3;
        r.instr_class = instr_class;
        r.op_index    = op_index;
        r.show_short  = sh;
        r.show_keep   = kp;
        r.show_return = rt;
        r.truncated   = trunc;
        return r;
    endfunction

    function automatic split_result_t build_instruction(
        input logic [1:0] byte_count, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] b3, input logic trunc);
        logic [1:0] cls;
        logic [4:0] idx;
        logic       sh;
        logic       kp;
        logic       rt;
        cls = svis_pkg::CLASS_BREAK;
        idx = '0;
        sh = 1'b0;
        kp = 1'b0;
        rt = 1'b0;
        if (!trunc) begin
            if (b1[4:0] != 5'd0) begin
                cls = svis_pkg::CLASS_ORDINARY;
                idx = b1[4:0];
                sh = b1[5];
                kp = b1[7];
                rt = b1[6];
            end else if (b1[7]) begin
                cls = svis_pkg::CLASS_LITERAL;
                idx = {2'b00, b1[7:5]};
                sh = b1[5];
                rt = b1[6];
            end else begin
                idx = {2'b00, b1[7:5]};
                cls = (b1[7:5] == 3'd0) ? svis_pkg::CLASS_BREAK : svis_pkg::CLASS_RESERVED;
            end
        end
        return make_result(img_base + img_start, byte_count, b1, b2, b3, cls, idx,
                           sh, kp, rt, trunc);
    endfunction

    function automatic bit split_byte(input logic [7:0] b, input logic last,
                                      output split_result_t res);
        logic [1:0] imm;
        bit         produced;
        produced = 1'b0;
        res = '0;
        imm = svis_pkg::is_literal(b) ? (b[5] ? 2'd2 : 2'd1) : 2'd0;
        if (img_held == 2'd0 || img_need == 2'd0) begin
            img_start = img_pos;
            img_opcode = b;
            if (imm == 2'd0 || last) begin
                res = build_instruction(2'd1, b, 8'h00, 8'h00, imm != 2'd0);
                produced = 1'b1;
                img_held = 2'd0;
                img_need = 2'd0;
            end else begin
                img_held = 2'd1;
                img_need = imm;
            end
        end else if (img_need == 2'd1) begin
            if (img_held >= 2'd2)
                res = build_instruction(2'd3, img_opcode, img_high, b, 1'b0);
            else
                res = build_instruction(2'd2, img_opcode, b, 8'h00, 1'b0);
            produced = 1'b1;
            img_held = 2'd0;
            img_need = 2'd0;
        end else if (last) begin
            res = build_instruction(2'd2, img_opcode, b, 8'h00, 1'b1);
            produced = 1'b1;
            img_held = 2'd0;
            img_need = 2'd0;
        end else begin
            img_high = b;
            img_held = 2'd2;
            img_need = 2'd1;
        end
        if (last) begin
            img_pos = '0;
            img_held = 2'd0;
            img_need = 2'd0;
        end else begin
            img_pos = img_pos + 16'd1;
        end
        return produced;
    endfunction

    function automatic string format_result(input split_result_t r);
        return $sformatf("addr=%h cnt=%0d bytes=%h %h %h class=%0d idx=%0d skr=%b%b%b trunc=%b",
                         r.address, r.byte_count, r.first_byte, r.second_byte, r.third_byte,
                         r.instr_class, r.op_index, r.show_short, r.show_keep, r.show_return,
                         r.truncated);
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic last, input bit typed,
                             input split_result_t typed_result);
        split_result_t predicted;
        while (!steady_flow && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        if (split_byte(b, last, predicted))
            pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                           input split_result_t res);
        directed_row_t row;
        row.value = b;
        row.last = last;
        row.typed = typed;
        row.result = res;
        directed_rows.push_back(row);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_load_base(input logic [15:0] value);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LOAD_BASE_ADDR;
        pwdata <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        img_base = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[15:0] !== value) begin
            if (error_count < 10)
                $display("load_base readback: expected %h actual %h", value, readback[15:0]);
            error_count++;
        end
    endtask

    task automatic feed_images(input int item_target);
        int sent;
        int length;
        logic [7:0] b;
        sent = 0;
        while (sent < item_target) begin
            length = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            for (int i = 0; i < length; i++) begin
                if ($urandom_range(0, 99) < 40)
                    b = {1'b1, 2'($urandom), 5'b00000};
                else
                    b = 8'($urandom);
                feed_byte(b, i == length - 1, 1'b0, '0);
            end
            sent += length;
        end
    endtask

    always @(posedge aclk) begin : result_check
        split_result_t got;
        split_result_t want;
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 11);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("stack_vm_instruction_splitter_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = make_result(m_tdata[15:0], m_tdata[17:16], m_tdata[25:18], m_tdata[33:26],
                              m_tdata[41:34], m_tdata[43:42], m_tdata[48:44], m_tdata[49],
                              m_tdata[50], m_tdata[51], m_tuser);
            if (pending_results.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected transfer: %s", format_result(got));
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.address !== want.address || got.byte_count !== want.byte_count ||
                    got.first_byte !== want.first_byte ||
                    got.second_byte !== want.second_byte ||
                    got.third_byte !== want.third_byte ||
                    got.instr_class !== want.instr_class ||
                    got.op_index !== want.op_index || got.show_short !== want.show_short ||
                    got.show_keep !== want.show_keep ||
                    got.show_return !== want.show_return ||
                    got.truncated !== want.truncated) begin
                    if (error_count < 10) begin
                        $display("mismatch expected: %s", format_result(want));
                        $display("mismatch actual:   %s", format_result(got));
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin
        img_base = svis_pkg::LOAD_BASE_RESET;
        img_pos = '0;
        img_start = '0;
        img_need = '0;
        img_held = '0;
        img_opcode = '0;
        img_high = '0;

        add_row(8'h00, 1'b0, 1'b1, make_result(16'h0100, 2'd1, 8'h00, 8'h00, 8'h00,
                svis_pkg::CLASS_BREAK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b0, '0);
        add_row(8'ha0, 1'b0, 1'b0, '0);
        add_row(8'h12, 1'b0, 1'b0, '0);
        add_row(8'h34, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b1, make_result(16'h0106, 2'd1, 8'hff, 8'h00, 8'h00,
                svis_pkg::CLASS_ORDINARY, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0));
        add_row(8'h20, 1'b0, 1'b0, '0);
        add_row(8'h60, 1'b0, 1'b0, '0);
        add_row(8'he0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'hc0, 1'b0, 1'b0, '0);
        add_row(8'h55, 1'b1, 1'b0, '0);
        add_row(8'h80, 1'b1, 1'b1, make_result(16'h0100, 2'd1, 8'h80, 8'h00, 8'h00,
                svis_pkg::CLASS_BREAK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(8'ha0, 1'b0, 1'b0, '0);
        add_row(8'h99, 1'b1, 1'b1, make_result(16'h0100, 2'd2, 8'ha0, 8'h99, 8'h00,
                svis_pkg::CLASS_BREAK, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(8'he0, 1'b0, 1'b0, '0);
        add_row(8'h11, 1'b0, 1'b0, '0);
        add_row(8'h22, 1'b1, 1'b0, '0);
        add_row(8'h1f, 1'b1, 1'b0, '0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            feed_byte(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].result);
        drain_results();

        set_load_base(16'h0000);
        feed_images(400);
        drain_results();

        set_load_base(16'hffff);
        steady_flow = 1'b1;
        feed_images(300);
        drain_results();
        steady_flow = 1'b0;

        // One long image of random bytes under a random load base.
        set_load_base(16'($urandom));
        for (int i = 0; i < LONG_IMAGE_BYTES; i++)
            feed_byte(8'($urandom), i == LONG_IMAGE_BYTES - 1, 1'b0, '0);
        drain_results();

        set_load_base(16'hfff0);
        feed_images(450);
        drain_results();

        if (error_count == 0 && pending_results.size() == 0)
            $display("stack_vm_instruction_splitter_unit verification clean");
        else
            $display("stack_vm_instruction_splitter_unit verification failed");
        $finish;
    end

endmodule
